@@ rtl/core/pcf_pkg.sv @@
// Shared constants, register codes and helpers for the perspective checker floor.
`default_nettype none
package pcf_pkg;

  localparam int COORD_BITS_DEF    = 12;
  localparam int FRACTION_BITS_DEF = 8;

  // register widths
  localparam int ROT_W    = 16;
  localparam int SCROLL_W = 24;
  localparam int CAM_W    = 16;
  localparam int SW_W     = 13;
  localparam int FH_W     = 13;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam int ROT_BITS  = 14;
  localparam int TILE_BIT  = 5;
  localparam int LAT_DIV_W = 8;
  localparam logic [LAT_DIV_W-1:0] LATERAL_DIV = 8'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS    = 3'd0,
    CFG_SIN    = 3'd1,
    CFG_SCROLL = 3'd2,
    CFG_CAM    = 3'd3,
    CFG_WIDTH  = 3'd4,
    CFG_FLOOR  = 3'd5
  } cfg_idx_t;

  localparam logic [ROT_W-1:0]    COS_RST    = 16'd16384;
  localparam logic [ROT_W-1:0]    SIN_RST    = 16'd0;
  localparam logic [SCROLL_W-1:0] SCROLL_RST = 24'd0;
  localparam logic [CAM_W-1:0]    CAM_RST    = 16'd8000;
  localparam logic [SW_W-1:0]     SW_RST     = 13'd1280;
  localparam logic [FH_W-1:0]     FH_RST     = 13'd360;

  // shading lanes: nonzero channel bases of both tiles
  localparam int SHADE_LANES = 4;
  localparam int LANE_G1 = 0;
  localparam int LANE_B1 = 1;
  localparam int LANE_R0 = 2;
  localparam int LANE_B0 = 3;
  localparam logic [7:0] SHADE_BASE [SHADE_LANES] = '{8'd150, 8'd255, 8'd180, 8'd100};

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/pcf_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with shared divisor and payload.
`default_nettype none
module pcf_div #(
  parameter int LANES = 1,
  parameter int NUM_W = 8,
  parameter int DEN_W = 8,
  parameter int QUO_W = 8,
  parameter int PAY_W = 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_vld,
  input  wire logic [LANES*NUM_W-1:0] in_num,
  input  wire logic [DEN_W-1:0]       in_den,
  input  wire logic [PAY_W-1:0]       in_pay,
  output logic                        out_vld,
  output logic [LANES*QUO_W-1:0]      out_quo,
  output logic [PAY_W-1:0]            out_pay
);
  import pcf_pkg::*;

  localparam int RW = max_int(NUM_W, DEN_W + QUO_W);

  logic             vld_r [QUO_W];
  logic [RW-1:0]    rem_r [QUO_W][LANES];
  logic [QUO_W-1:0] quo_r [QUO_W][LANES];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [PAY_W-1:0] pay_r [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic             vld_in;
    logic [DEN_W-1:0] den_in;
    logic [PAY_W-1:0] pay_in;
    logic [RW-1:0]    rem_in  [LANES];
    logic [QUO_W-1:0] quo_in  [LANES];
    logic [RW-1:0]    rem_nxt [LANES];
    logic [QUO_W-1:0] quo_nxt [LANES];

    if (s == 0) begin : g_first
      assign vld_in = in_vld;
      assign den_in = in_den;
      assign pay_in = in_pay;
      for (genvar l = 0; l < LANES; l++) begin : g_ld
        assign rem_in[l] = RW'(in_num[l*NUM_W +: NUM_W]);
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign den_in = den_r[s-1];
      assign pay_in = pay_r[s-1];
      for (genvar l = 0; l < LANES; l++) begin : g_ld
        assign rem_in[l] = rem_r[s-1][l];
        assign quo_in[l] = quo_r[s-1][l];
      end
    end

    // trial subtract of the divisor at this quotient weight
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RW-1:0] trial;
      logic          ge;
      assign trial      = RW'(den_in) << (QUO_W - 1 - s);
      assign ge         = rem_in[l] >= trial;
      assign rem_nxt[l] = ge ? rem_in[l] - trial : rem_in[l];
      assign quo_nxt[l] = quo_in[l] | (QUO_W'(ge) << (QUO_W - 1 - s));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s] <= den_in;
        pay_r[s] <= pay_in;
        for (int l = 0; l < LANES; l++) begin
          rem_r[s][l] <= rem_nxt[l];
          quo_r[s][l] <= quo_nxt[l];
        end
      end
    end
  end

  assign out_vld = vld_r[QUO_W-1];
  assign out_pay = pay_r[QUO_W-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign out_quo[l*QUO_W +: QUO_W] = quo_r[QUO_W-1][l];
  end

endmodule
`default_nettype wire

@@ rtl/core/perspective_checker_floor_pixel_top.sv @@
// Top level of the perspective checker floor pixel pipeline.
// Takes one pixel request per clock and returns its shaded tile colour in request
// order. Two bit-per-stage divider chains make up most of the pipeline: the shading
// ratio (8 stages) and the row depth (16+FRACTION_BITS stages). The lateral divide by
// 250 is a reciprocal multiply over two stages. A held result freezes the whole
// pipeline, so throughput is one pixel per clock while the output is taken. Write
// configuration only with the pipeline empty.
`default_nettype none
module perspective_checker_floor_pixel_top #(
  parameter int COORD_BITS    = pcf_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = pcf_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [COORD_BITS-1:0]      in_pixel_x,
  input  wire logic [COORD_BITS-1:0]      in_pixel_y,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic                            out_checker_bit,
  input  wire logic                       cfg_we,
  input  wire logic [pcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pcf_pkg::CFG_W-1:0]  cfg_data
);
  import pcf_pkg::*;

  localparam int YW     = COORD_BITS + 1;
  localparam int ZW     = CAM_W + FRACTION_BITS;
  localparam int HALF_W = SW_W - 1;
  localparam int SX_W   = max_int(COORD_BITS, HALF_W) + 1;
  localparam int PRW    = SX_W + ZW + 1;
  localparam int MAGW   = SX_W + ZW;
  localparam int Q250W  = MAGW - 7;
  localparam int WXW    = MAGW - 6;
  localparam int PW     = WXW + ROT_W;
  localparam int AW     = PW + 1;
  localparam int UW     = AW + 1;
  localparam int TS     = ROT_BITS + FRACTION_BITS;
  localparam int SCR_SH = TS - 8;
  localparam int CMPW   = max_int(YW, FH_W);
  localparam int SHN_W  = 8 + FH_W;
  localparam int SHW    = SHADE_LANES * 8;
  localparam int TW     = TILE_BIT + 1;

  // reciprocal of 250 rounded up; its error times 2^MAGW stays below 2^RK,
  // so the quotient is exact for every magnitude
  localparam int RK    = MAGW + LAT_DIV_W;
  localparam int RCW   = MAGW + 1;
  localparam int LOW_W = (MAGW + 1) / 2;
  localparam int HIW_W = MAGW - LOW_W;
  localparam int PLW   = LOW_W + RCW;
  localparam int PHW   = HIW_W + RCW;
  localparam int PSW   = MAGW + RCW;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << RK) + 64'(LATERAL_DIV) - 64'd1) / 64'(LATERAL_DIV);
  localparam logic [RCW-1:0] RECIP = RECIP64[RCW-1:0];

  // ---------------- configuration registers
  logic signed [ROT_W-1:0] cos_r, sin_r;
  logic [SCROLL_W-1:0]     scroll_r;
  logic [CAM_W-1:0]        cam_r;
  logic [SW_W-1:0]         sw_r;
  logic [FH_W-1:0]         fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r    <= COS_RST;
      sin_r    <= SIN_RST;
      scroll_r <= SCROLL_RST;
      cam_r    <= CAM_RST;
      sw_r     <= SW_RST;
      fh_r     <= FH_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COS:    cos_r    <= cfg_data[ROT_W-1:0];
        CFG_SIN:    sin_r    <= cfg_data[ROT_W-1:0];
        CFG_SCROLL: scroll_r <= cfg_data[SCROLL_W-1:0];
        CFG_CAM:    cam_r    <= cfg_data[CAM_W-1:0];
        CFG_WIDTH:  sw_r     <= cfg_data[SW_W-1:0];
        CFG_FLOOR:  fh_r     <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // the whole pipeline advances unless a result is held at the output
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- S0: row index and shading numerator
  logic                  v0_r;
  logic [COORD_BITS-1:0] px0_r;
  logic [YW-1:0]         y10_r;
  logic [FH_W-1:0]       minv0_r;
  logic [YW-1:0]         y1_nxt;

  assign y1_nxt = YW'(in_pixel_y) + YW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      px0_r   <= in_pixel_x;
      y10_r   <= y1_nxt;
      minv0_r <= (CMPW'(y1_nxt) < CMPW'(fh_r)) ? FH_W'(y1_nxt) : fh_r;
    end
  end

  // ---------------- S1: scaled channel numerators
  logic                     v1_r;
  logic [COORD_BITS-1:0]    px1_r;
  logic [YW-1:0]            y11_r;
  logic [SHADE_LANES*SHN_W-1:0] shn1_r;
  logic [SHADE_LANES*SHN_W-1:0] shn_nxt;

  for (genvar l = 0; l < SHADE_LANES; l++) begin : g_shn
    assign shn_nxt[l*SHN_W +: SHN_W] = SHN_W'(SHADE_BASE[l]) * SHN_W'(minv0_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= v0_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      px1_r  <= px0_r;
      y11_r  <= y10_r;
      shn1_r <= shn_nxt;
    end
  end

  // ---------------- shading divide by floor height
  logic                  sd_vld;
  logic [SHW-1:0]        sd_quo;
  logic [COORD_BITS+YW-1:0] sd_pay;

  pcf_div #(
    .LANES(SHADE_LANES), .NUM_W(SHN_W), .DEN_W(FH_W), .QUO_W(8),
    .PAY_W(COORD_BITS + YW)
  ) u_shade_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(v1_r), .in_num(shn1_r), .in_den(fh_r), .in_pay({px1_r, y11_r}),
    .out_vld(sd_vld), .out_quo(sd_quo), .out_pay(sd_pay)
  );

  // ---------------- row depth divide
  logic                      zd_vld;
  logic [ZW-1:0]             zd_quo;
  logic [COORD_BITS+SHW-1:0] zd_pay;

  pcf_div #(
    .LANES(1), .NUM_W(ZW), .DEN_W(YW), .QUO_W(ZW), .PAY_W(COORD_BITS + SHW)
  ) u_depth_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(sd_vld), .in_num({cam_r, {FRACTION_BITS{1'b0}}}),
    .in_den(sd_pay[YW-1:0]), .in_pay({sd_pay[COORD_BITS+YW-1:YW], sd_quo}),
    .out_vld(zd_vld), .out_quo(zd_quo), .out_pay(zd_pay)
  );

  // ---------------- S2: centered column
  logic                   v2_r;
  logic signed [SX_W-1:0] sx2_r;
  logic [ZW-1:0]          z2_r;
  logic [SHW-1:0]         sh2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= zd_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sx2_r <= SX_W'(zd_pay[COORD_BITS+SHW-1:SHW]) - SX_W'(sw_r[SW_W-1:1]);
      z2_r  <= zd_quo;
      sh2_r <= zd_pay[SHW-1:0];
    end
  end

  // ---------------- S3: lateral product
  logic                  v3_r;
  logic signed [PRW-1:0] prod3_r;
  logic [ZW-1:0]         z3_r;
  logic [SHW-1:0]        sh3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      prod3_r <= sx2_r * $signed({1'b0, z2_r});
      z3_r    <= z2_r;
      sh3_r   <= sh2_r;
    end
  end

  // ---------------- S4: sign and magnitude for the divide by 250
  logic            v4_r;
  logic [MAGW-1:0] mag4_r;
  logic            neg4_r;
  logic [ZW-1:0]   z4_r;
  logic [SHW-1:0]  sh4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mag4_r <= prod3_r[PRW-1] ? MAGW'(-prod3_r) : MAGW'(prod3_r);
      neg4_r <= prod3_r[PRW-1];
      z4_r   <= z3_r;
      sh4_r  <= sh3_r;
    end
  end

  // ---------------- L1: reciprocal partial products of both magnitude halves
  logic           vl1_r;
  logic [PLW-1:0] plo_l1_r;
  logic [PHW-1:0] phi_l1_r;
  logic           neg_l1_r;
  logic [ZW-1:0]  z_l1_r;
  logic [SHW-1:0] sh_l1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vl1_r <= 1'b0;
    else if (en) vl1_r <= v4_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      plo_l1_r <= PLW'(mag4_r[LOW_W-1:0]) * PLW'(RECIP);
      phi_l1_r <= PHW'(mag4_r[MAGW-1:LOW_W]) * PHW'(RECIP);
      neg_l1_r <= neg4_r;
      z_l1_r   <= z4_r;
      sh_l1_r  <= sh4_r;
    end
  end

  // ---------------- L2: combine partial products and keep the quotient bits
  logic             vl2_r;
  logic [Q250W-1:0] lq_l2_r;
  logic             neg_l2_r;
  logic [ZW-1:0]    z_l2_r;
  logic [SHW-1:0]   sh_l2_r;
  logic [PSW-1:0]   psum;

  assign psum = (PSW'(phi_l1_r) << LOW_W) + PSW'(plo_l1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) vl2_r <= 1'b0;
    else if (en) vl2_r <= vl1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      lq_l2_r  <= psum[PSW-1:RK];
      neg_l2_r <= neg_l1_r;
      z_l2_r   <= z_l1_r;
      sh_l2_r  <= sh_l1_r;
    end
  end

  // ---------------- S5: signed lateral offset, truncated toward zero
  logic                  v5_r;
  logic signed [WXW-1:0] wx5_r;
  logic [ZW-1:0]         z5_r;
  logic [SHW-1:0]        sh5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= vl2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      wx5_r <= neg_l2_r ? -WXW'(lq_l2_r) : WXW'(lq_l2_r);
      z5_r  <= z_l2_r;
      sh5_r <= sh_l2_r;
    end
  end

  // ---------------- S6: rotation products
  logic                 v6_r;
  logic signed [PW-1:0] wxc6_r, wxs6_r, zc6_r, zs6_r;
  logic [SHW-1:0]       sh6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      wxc6_r <= wx5_r * cos_r;
      wxs6_r <= wx5_r * sin_r;
      zc6_r  <= $signed({1'b0, z5_r}) * cos_r;
      zs6_r  <= $signed({1'b0, z5_r}) * sin_r;
      sh6_r  <= sh5_r;
    end
  end

  // ---------------- S7: rotated point
  logic                 v7_r;
  logic signed [AW-1:0] a7_r, b7_r;
  logic [SHW-1:0]       sh7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en) v7_r <= v6_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a7_r  <= AW'(wxc6_r) - AW'(zs6_r);
      b7_r  <= AW'(wxs6_r) + AW'(zc6_r);
      sh7_r <= sh6_r;
    end
  end

  // ---------------- S8: add scroll
  logic                 v8_r;
  logic signed [UW-1:0] u8_r, w8_r;
  logic [SHW-1:0]       sh8_r;
  logic signed [UW-1:0] scr;

  assign scr = UW'(scroll_r) << SCR_SH;

  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (en) v8_r <= v7_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      u8_r  <= UW'(a7_r) + scr;
      w8_r  <= UW'(b7_r) + scr;
      sh8_r <= sh7_r;
    end
  end

  // ---------------- S9: tile select and output register
  logic [TW-1:0] ui, vi;
  logic          bit_nxt, fhz;

  // round negative values up so the integer part truncates toward zero
  assign ui = u8_r[TS+TILE_BIT:TS] + TW'(u8_r[UW-1] && (|u8_r[TS-1:0]));
  assign vi = w8_r[TS+TILE_BIT:TS] + TW'(w8_r[UW-1] && (|w8_r[TS-1:0]));
  assign bit_nxt = ui[TILE_BIT] ^ vi[TILE_BIT];
  assign fhz = (fh_r == '0);

  logic out_valid_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= v8_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_checker_bit <= bit_nxt;
      if (bit_nxt) begin
        out_red   <= 8'd0;
        out_green <= fhz ? SHADE_BASE[LANE_G1] : sh8_r[LANE_G1*8 +: 8];
        out_blue  <= fhz ? SHADE_BASE[LANE_B1] : sh8_r[LANE_B1*8 +: 8];
      end else begin
        out_red   <= fhz ? SHADE_BASE[LANE_R0] : sh8_r[LANE_R0*8 +: 8];
        out_green <= 8'd0;
        out_blue  <= fhz ? SHADE_BASE[LANE_B0] : sh8_r[LANE_B0*8 +: 8];
      end
    end
  end

  // ---------------- assertions
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(v8_r) && $stable(zd_vld) && $stable(vl2_r)))
    else $error("pipeline moved while the output was held");

  a_blue_tile_no_red: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_checker_bit) |-> (out_red == 8'd0))
    else $error("blue tile carries red");

  a_magenta_no_green: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_checker_bit) |-> (out_green == 8'd0))
    else $error("magenta tile carries green");

  a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_checker_bit && fhz) |-> (out_red == SHADE_BASE[LANE_R0]))
    else $error("zero floor height not shaded at full scale");

endmodule
`default_nettype wire
